[rtl/dab_pkg.sv]
// Shared types and constants for the dual-arena bump allocator.
// Holds field widths, operation and register codes, reset values and the
// command/status structs that join controller and datapath. No dependencies.
`default_nettype none

package dab_pkg;

  // Default sizing handed to the top-level parameters
  localparam int DEF_SLOT_COUNT   = 64;
  localparam int DEF_ADDRESS_BITS = 26;

  // Stream item field widths
  localparam int OP_W         = 3;
  localparam int SIZE_W       = 26;
  localparam int SLOT_FIELD_W = 6;
  localparam int SLOT_FIELD_N = 1 << SLOT_FIELD_W;
  localparam int FIELD_W      = 26;

  // Packed bus widths (rounded up to whole bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 56;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Bump pointers live in the first two slot table entries
  localparam int LARGE_PTR_IDX = 0;
  localparam int FAST_PTR_IDX  = 1;

  // Request sizes are rounded up to a multiple of this mask plus one
  localparam int SIZE_ALIGN_MASK = 3;

  // Register reset values (truncated to the address width where used)
  localparam logic [31:0] FAST_BASE_RST       = 32'h0300_0000;
  localparam logic [31:0] LARGE_BASE_RST      = 32'h0200_0000;
  localparam logic [31:0] FAST_LIMIT_RST      = 32'h0300_7800;
  localparam logic [31:0] LARGE_LIMIT_RST     = 32'h0204_0000;
  localparam logic [31:0] FAST_REPORT_END_RST = 32'h0300_7800;

  // Operation codes; the remaining code is a no-op returning zeros
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR       = 3'd0,
    OP_ALLOC_FAST  = 3'd1,
    OP_ALLOC_LARGE = 3'd2,
    OP_SLOT_FAST   = 3'd3,
    OP_SLOT_LARGE  = 3'd4,
    OP_FREE_FAST   = 3'd5,
    OP_FREE_LARGE  = 3'd6
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_BASE       = 3'd0,
    CFG_LARGE_BASE      = 3'd1,
    CFG_FAST_LIMIT      = 3'd2,
    CFG_LARGE_LIMIT     = 3'd3,
    CFG_FAST_REPORT_END = 3'd4
  } cfg_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // latch input item, start slot table read
    logic commit;    // apply state update and load the result register
    logic sweep_en;  // zero one slot table entry this cycle
  } dab_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // result register can take a new result
    logic is_clear;    // item in flight is a clear
    logic sweep_last;  // sweep is at the final entry
  } dab_sts_t;

endpackage

`default_nettype wire

[rtl/dual_arena_bump_allocator_unit.sv]
// Dual-arena bump allocator, top level: dab_ctrl sequencer plus dab_datapath.
// Each input transfer latches the item and starts the slot table read; the result
// is registered once the result register is free, and no new item is taken before
// then. A clear then also zeroes the table, one entry a cycle, with s_tready low.
// Reset is asynchronous active low; afterward a full table sweep runs
// with s_tready low. Config writes are taken every cycle (cfg_ready_o high).
`default_nettype none

module dual_arena_bump_allocator_unit #(
  parameter int SLOT_COUNT   = dab_pkg::DEF_SLOT_COUNT,
  parameter int ADDRESS_BITS = dab_pkg::DEF_ADDRESS_BITS
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Request stream
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // s_tdata: operation[2:0], request_size[28:3], slot_index[34:29], zeros above
  input  wire  [dab_pkg::S_TDATA_W-1:0]  s_tdata,
  // Result stream
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // m_tdata: granted_address[25:0], no_space[26], free_bytes[52:27], zeros above
  output logic [dab_pkg::M_TDATA_W-1:0]  m_tdata,
  // Configuration write channel
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [dab_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [dab_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  dab_pkg::dab_cmd_t cmd;
  dab_pkg::dab_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  dab_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // Datapath
  dab_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

[rtl/dab_ctrl.sv]
// Sequencing controller for the dual-arena bump allocator.
// One-hot state machine issuing accept/commit/sweep commands to dab_datapath.
// Depends on dab_pkg for the command and status structs.
`default_nettype none

module dab_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  dab_pkg::dab_sts_t sts_i,
  output dab_pkg::dab_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_SWEEP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d      = state_q;
    s_tready     = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.is_clear ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

  // State register; reset starts with a table sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item blocks further input until it is done
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !s_tready)
    else $error("input taken while an item is in flight");

  // A committed clear is followed by the table sweep
  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && sts_i.is_clear) |=> cmd_o.sweep_en)
    else $error("clear did not start the slot table sweep");

endmodule

`default_nettype wire

[rtl/dab_datapath.sv]
// Datapath for the dual-arena bump allocator: config registers, bump
// pointers, slot table memory, allocation arithmetic and result register.
// Depends on dab_pkg; driven by dab_ctrl commands.
`default_nettype none

module dab_datapath #(
  parameter int SLOT_COUNT   = dab_pkg::DEF_SLOT_COUNT,
  parameter int ADDRESS_BITS = dab_pkg::DEF_ADDRESS_BITS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  dab_pkg::dab_cmd_t                 cmd_i,
  output dab_pkg::dab_sts_t                 sts_o,
  input  wire  [dab_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [dab_pkg::M_TDATA_W-1:0]     m_tdata,
  input  wire                               cfg_valid_i,
  input  wire  [dab_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [dab_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int RSIZE_W = dab_pkg::SIZE_W + 1;
  localparam int SUM_W   = ((ADDRESS_BITS > RSIZE_W) ? ADDRESS_BITS : RSIZE_W) + 1;
  localparam int WIDE_W  = (ADDRESS_BITS > dab_pkg::FIELD_W) ? ADDRESS_BITS
                                                             : dab_pkg::FIELD_W;
  localparam int OP_LO   = 0;
  localparam int SIZE_LO = OP_LO + dab_pkg::OP_W;
  localparam int SLOT_LO = SIZE_LO + dab_pkg::SIZE_W;
  localparam int PAD_W   = dab_pkg::M_TDATA_W - 2 * dab_pkg::FIELD_W - 1;

  typedef logic [ADDRESS_BITS-1:0] addr_t;

  // Input field unpack
  logic [dab_pkg::OP_W-1:0]         in_op;
  logic [dab_pkg::SIZE_W-1:0]       in_size;
  logic [dab_pkg::SLOT_FIELD_W-1:0] in_slot;
  logic [RSIZE_W-1:0]               in_rsize;
  logic [SLOT_W-1:0]                in_slot_red;

  assign in_op    = s_tdata[SIZE_LO-1:OP_LO];
  assign in_size  = s_tdata[SLOT_LO-1:SIZE_LO];
  assign in_slot  = s_tdata[SLOT_LO+dab_pkg::SLOT_FIELD_W-1:SLOT_LO];
  assign in_rsize = (RSIZE_W'(in_size) + RSIZE_W'(dab_pkg::SIZE_ALIGN_MASK))
                  & ~RSIZE_W'(dab_pkg::SIZE_ALIGN_MASK);

  // Slot index reduced modulo the table depth through a constant table
  logic [SLOT_W-1:0] slot_map [dab_pkg::SLOT_FIELD_N];
  for (genvar g = 0; g < dab_pkg::SLOT_FIELD_N; g++) begin : g_slot_map
    localparam int unsigned Red = g % SLOT_COUNT;
    assign slot_map[g] = SLOT_W'(Red);
  end
  assign in_slot_red = slot_map[in_slot];

  // Configuration registers
  addr_t fast_base_q, large_base_q, fast_limit_q, large_limit_q, fast_rend_q;
  addr_t cfg_val;
  assign cfg_val = cfg_data_i[ADDRESS_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_base_q   <= dab_pkg::FAST_BASE_RST[ADDRESS_BITS-1:0];
      large_base_q  <= dab_pkg::LARGE_BASE_RST[ADDRESS_BITS-1:0];
      fast_limit_q  <= dab_pkg::FAST_LIMIT_RST[ADDRESS_BITS-1:0];
      large_limit_q <= dab_pkg::LARGE_LIMIT_RST[ADDRESS_BITS-1:0];
      fast_rend_q   <= dab_pkg::FAST_REPORT_END_RST[ADDRESS_BITS-1:0];
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dab_pkg::CFG_FAST_BASE:       fast_base_q   <= cfg_val;
        dab_pkg::CFG_LARGE_BASE:      large_base_q  <= cfg_val;
        dab_pkg::CFG_FAST_LIMIT:      fast_limit_q  <= cfg_val;
        dab_pkg::CFG_LARGE_LIMIT:     large_limit_q <= cfg_val;
        dab_pkg::CFG_FAST_REPORT_END: fast_rend_q   <= cfg_val;
        default: ;
      endcase
    end
  end

  // Item registers, loaded on accept
  logic [dab_pkg::OP_W-1:0] op_q;
  logic [RSIZE_W-1:0]       size_q;
  logic [SLOT_W-1:0]        slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op;
      size_q <= in_rsize;
      slot_q <= in_slot_red;
    end
  end

  // Slot table memory with registered read
  addr_t             mem_q [SLOT_COUNT];
  addr_t             rdata_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  addr_t             mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rdata_q <= mem_q[in_slot_red];
    end
  end

  // Bump pointers
  addr_t fast_ptr_q, fast_ptr_d, large_ptr_q, large_ptr_d;

  // Operation decode
  logic is_clear, is_alloc, is_slot, fast_first, is_free_fast, is_free_large;

  always_comb begin
    is_clear      = 1'b0;
    is_alloc      = 1'b0;
    is_slot       = 1'b0;
    fast_first    = 1'b0;
    is_free_fast  = 1'b0;
    is_free_large = 1'b0;
    case (op_q)
      dab_pkg::OP_CLEAR:       is_clear = 1'b1;
      dab_pkg::OP_ALLOC_FAST:  begin is_alloc = 1'b1; fast_first = 1'b1; end
      dab_pkg::OP_ALLOC_LARGE: is_alloc = 1'b1;
      dab_pkg::OP_SLOT_FAST:   begin is_slot = 1'b1; fast_first = 1'b1; end
      dab_pkg::OP_SLOT_LARGE:  is_slot = 1'b1;
      dab_pkg::OP_FREE_FAST:   is_free_fast = 1'b1;
      dab_pkg::OP_FREE_LARGE:  is_free_large = 1'b1;
      default: ;
    endcase
  end

  // Allocation arithmetic at full width, both arenas in parallel
  logic [SUM_W-1:0] fast_sum, large_sum;
  logic             fast_ok, large_ok, use_fast, use_large, alloc_ok;
  logic             slot_is_large, slot_is_fast, slot_hit, do_alloc, slot_wr;
  addr_t            stored, alloc_addr;

  assign fast_sum  = SUM_W'(fast_ptr_q) + SUM_W'(size_q);
  assign large_sum = SUM_W'(large_ptr_q) + SUM_W'(size_q);
  assign fast_ok   = fast_sum < SUM_W'(fast_limit_q);
  assign large_ok  = large_sum < SUM_W'(large_limit_q);

  assign use_fast  = fast_first ? fast_ok : (!large_ok && fast_ok);
  assign use_large = fast_first ? (!fast_ok && large_ok) : large_ok;
  assign alloc_ok  = use_fast || use_large;
  assign alloc_addr = use_fast ? fast_ptr_q : (use_large ? large_ptr_q : '0);

  // Slot lookup: the first two entries are the bump pointers
  assign slot_is_large = slot_q == SLOT_W'(dab_pkg::LARGE_PTR_IDX);
  assign slot_is_fast  = slot_q == SLOT_W'(dab_pkg::FAST_PTR_IDX);
  assign stored   = slot_is_large ? large_ptr_q : (slot_is_fast ? fast_ptr_q : rdata_q);
  assign slot_hit = is_slot && (stored != '0);
  assign do_alloc = is_alloc || (is_slot && (stored == '0));
  assign slot_wr  = is_slot && (stored == '0) && alloc_ok;

  // Pointer update; a slot write to a pointer entry overrides the bump
  always_comb begin
    fast_ptr_d  = fast_ptr_q;
    large_ptr_d = large_ptr_q;
    if (cmd_i.commit) begin
      if (is_clear) begin
        fast_ptr_d  = fast_base_q;
        large_ptr_d = large_base_q;
      end else if (do_alloc) begin
        if (use_fast)  fast_ptr_d  = fast_sum[ADDRESS_BITS-1:0];
        if (use_large) large_ptr_d = large_sum[ADDRESS_BITS-1:0];
        if (slot_wr && slot_is_fast)  fast_ptr_d  = alloc_addr;
        if (slot_wr && slot_is_large) large_ptr_d = alloc_addr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_ptr_q  <= '0;
      large_ptr_q <= '0;
    end else begin
      fast_ptr_q  <= fast_ptr_d;
      large_ptr_q <= large_ptr_d;
    end
  end

  // Sweep counter walks the whole table writing zeros
  logic [SLOT_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic              sweep_last;

  assign sweep_last = sweep_cnt_q == SLOT_W'(SLOT_COUNT - 1);

  always_comb begin
    sweep_cnt_d = sweep_cnt_q;
    if (cmd_i.sweep_en) begin
      sweep_cnt_d = sweep_last ? '0 : sweep_cnt_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else begin
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  // Memory write port: sweep or slot record
  assign mem_we    = cmd_i.sweep_en
                  || (cmd_i.commit && slot_wr && !slot_is_fast && !slot_is_large);
  assign mem_waddr = cmd_i.sweep_en ? sweep_cnt_q : slot_q;
  assign mem_wdata = cmd_i.sweep_en ? '0 : alloc_addr;

  // Result fields
  addr_t                       res_addr, res_free;
  logic                        res_ns;
  logic [WIDE_W-1:0]           addr_wide, free_wide;
  logic [dab_pkg::FIELD_W-1:0] addr_fld, free_fld;

  always_comb begin
    res_addr = '0;
    res_ns   = 1'b0;
    res_free = '0;
    if (slot_hit) begin
      res_addr = stored;
    end else if (do_alloc) begin
      res_addr = alloc_addr;
      res_ns   = !alloc_ok;
    end
    if (is_free_fast) begin
      res_free = (fast_rend_q > fast_ptr_q) ? fast_rend_q - fast_ptr_q : '0;
    end else if (is_free_large) begin
      res_free = (large_limit_q > large_ptr_q) ? large_limit_q - large_ptr_q : '0;
    end
  end

  assign addr_wide = WIDE_W'(res_addr);
  assign free_wide = WIDE_W'(res_free);
  assign addr_fld  = addr_wide[dab_pkg::FIELD_W-1:0];
  assign free_fld  = free_wide[dab_pkg::FIELD_W-1:0];

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [dab_pkg::M_TDATA_W-1:0] out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (m_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {PAD_W'(0), free_fld, res_ns, addr_fld};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

  // Status to controller
  assign sts_o.out_free   = !out_valid_q || m_tready;
  assign sts_o.is_clear   = is_clear;
  assign sts_o.sweep_last = sweep_last;

  // A commit never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || m_tready))
    else $error("result register overwritten before transfer");

  // A failed request always reports address zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tdata[dab_pkg::FIELD_W]) |-> (m_tdata[dab_pkg::FIELD_W-1:0] == '0))
    else $error("no_space result with nonzero address");

endmodule

`default_nettype wire
